// ===== hw/rtl/flr_pkg.sv =====
package flr_pkg;

	// Input operation codes.
	localparam logic [1:0] OP_RX_BYTE = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_TX_DONE = 2'd2;

	// Result kinds.
	localparam logic [2:0] KIND_ACCEPT  = 3'd0;
	localparam logic [2:0] KIND_PAYLOAD = 3'd1;
	localparam logic [2:0] KIND_BAD_SUM = 3'd2;
	localparam logic [2:0] KIND_ACK     = 3'd3;
	localparam logic [2:0] KIND_RESEND  = 3'd4;
	localparam logic [2:0] KIND_DROPPED = 3'd5;
	localparam logic [2:0] KIND_RETRY   = 3'd6;

	// Configuration register indexes.
	localparam logic CFG_ACK_TIMEOUT = 1'b0;
	localparam logic CFG_HOST_MODE   = 1'b1;

	// Link framing bytes.
	localparam logic [7:0] BYTE_FRAME_START = 8'hff;
	localparam logic [7:0] BYTE_FRAME_MARK  = 8'hdd;
	localparam logic [7:0] BYTE_CTRL_START  = 8'hfd;
	localparam logic [7:0] BYTE_CTRL_ACK    = 8'h02;
	localparam logic [7:0] BYTE_CTRL_NAK    = 8'h03;

	localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd1000;

	// Receive parser phase.
	typedef enum logic [2:0] {
		PH_HUNT,
		PH_GOT_FF,
		PH_GOT_FD,
		PH_CODE,
		PH_LEN,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	// Item control: taking items, or replaying a stored payload.
	typedef enum logic [1:0] {
		CTRL_ACCEPT,
		CTRL_READ,
		CTRL_WAIT
	} ctrl_t;

	// True when a message code has no handler in the selected mode.
	function automatic logic is_unknown(input logic [7:0] code, input logic host);
		logic unk;
		case (code) inside
			8'h01, 8'h03, 8'h04, 8'h05, 8'h20, 8'h21: unk = 1'b0;
			8'h7f: unk = host;
			8'h81, 8'h82, 8'h83, 8'h86, 8'ha0, 8'hff: unk = ~host;
			default: unk = 1'b1;
		endcase
		return unk;
	endfunction

endpackage

// ===== hw/rtl/flr_ram.sv =====
module flr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/framed_link_receiver_ack_retry.sv =====
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    operation, rx_byte
// result    out        out_valid / out_ready  kind, msg_code, data_byte, unknown_code,
//                                             payload_len, last, retries
// config    in         cfg_we                 cfg_index, cfg_data
//
// Outside a replay, an item is taken whenever the result register is free or being emptied.
// A good frame's checksum byte then replays its payload from the payload RAM, each byte
// first read from the RAM and then loaded into the result register; no item is taken meanwhile.
// A stalled result holds the block. Reset clears all control state; the payload RAM is
// not cleared, as only entries written in the current frame are ever read.
module framed_link_receiver_ack_retry #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  msg_code,
	output logic [7:0]  data_byte,
	output logic        unknown_code,
	output logic [7:0]  payload_len,
	output logic        last,
	output logic [7:0]  retries,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	import flr_pkg::*;

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	// Configuration registers.
	logic [15:0] ack_timeout_q;
	logic        host_mode_q;

	// Link state.
	phase_t      phase_q, phase_d;
	ctrl_t       ctrl_q, ctrl_d;
	logic [7:0]  frame_code_q, frame_code_d;
	logic [7:0]  frame_length_q, frame_length_d;
	logic [7:0]  bytes_seen_q, bytes_seen_d;
	logic [7:0]  running_sum_q, running_sum_d;
	logic        waiting_q, waiting_d;
	logic [15:0] ack_timer_q, ack_timer_d;
	logic [7:0]  retry_q, retry_d;
	logic [AW-1:0] emit_idx_q;
	logic [AW-1:0] emit_end_q;

	// Result register.
	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [7:0]  msg_code_q;
	logic [7:0]  data_byte_q;
	logic        unknown_q;
	logic [7:0]  payload_len_q;
	logic        last_q;
	logic [7:0]  retries_q;

	// Step results.
	logic        take;
	logic        out_free;
	logic        res_valid;
	logic [2:0]  res_kind;
	logic [7:0]  res_code;
	logic        res_unknown;
	logic [7:0]  res_plen;
	logic        res_last;
	logic        start_emit;
	logic        byte_load;
	logic        ram_we;
	logic        ram_re;
	logic [7:0]  ram_rdata;

	logic [7:0]  plen;
	logic [7:0]  bytes_next;
	logic [8:0]  bytes_next_ext;
	logic [15:0] timer_inc;
	logic [15:0] limit;
	logic [7:0]  retry_bump;
	logic [7:0]  sum_with_byte;
	logic        sum_ok;

	assign out_free = ~out_valid_q | out_ready;
	assign take     = in_valid & in_ready;

	assign plen           = frame_length_q - 8'd1;
	assign bytes_next     = bytes_seen_q + 8'd1;
	assign bytes_next_ext = {1'b0, bytes_next} + 9'd1;
	assign timer_inc      = (ack_timer_q != 16'hffff) ? ack_timer_q + 16'd1 : ack_timer_q;
	assign limit          = (ack_timeout_q != 16'd0) ? ack_timeout_q : 16'd1;
	assign retry_bump     = (retry_q != 8'hff) ? retry_q + 8'd1 : retry_q;
	assign sum_with_byte  = running_sum_q + rx_byte;
	assign sum_ok         = (8'(8'h00 - running_sum_q) == rx_byte);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q <= ACK_TIMEOUT_RESET;
			host_mode_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data;
				CFG_HOST_MODE:   host_mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Parser phase and link state update for one item.
	always_comb begin
		phase_d        = phase_q;
		frame_code_d   = frame_code_q;
		frame_length_d = frame_length_q;
		bytes_seen_d   = bytes_seen_q;
		running_sum_d  = running_sum_q;
		waiting_d      = waiting_q;
		ack_timer_d    = ack_timer_q;
		retry_d        = retry_q;
		if (operation == OP_RX_BYTE) begin
			unique case (phase_q)
				PH_GOT_FF: begin
					if (rx_byte == BYTE_FRAME_MARK) phase_d = PH_CODE;
					else if (rx_byte == BYTE_FRAME_START) phase_d = PH_GOT_FF;
					else if (rx_byte == BYTE_CTRL_START) phase_d = PH_GOT_FD;
					else phase_d = PH_HUNT;
				end
				PH_GOT_FD: begin
					if (rx_byte == BYTE_CTRL_ACK) begin
						waiting_d = 1'b0;
						retry_d   = 8'd0;
						phase_d   = PH_HUNT;
					end else if (rx_byte == BYTE_CTRL_NAK) begin
						ack_timer_d = 16'd0;
						retry_d     = retry_bump;
						phase_d     = PH_HUNT;
					end else if (rx_byte == BYTE_FRAME_START) phase_d = PH_GOT_FF;
					else if (rx_byte == BYTE_CTRL_START) phase_d = PH_GOT_FD;
					else phase_d = PH_HUNT;
				end
				PH_CODE: begin
					frame_code_d  = rx_byte;
					running_sum_d = rx_byte;
					bytes_seen_d  = 8'd0;
					phase_d       = PH_LEN;
				end
				PH_LEN: begin
					frame_length_d = rx_byte;
					running_sum_d  = sum_with_byte;
					if (rx_byte == 8'd0) phase_d = PH_HUNT;
					else if (rx_byte == 8'd1) phase_d = PH_CHECK;
					else phase_d = PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					bytes_seen_d  = bytes_next;
					running_sum_d = sum_with_byte;
					if (bytes_next_ext >= {1'b0, frame_length_q}) phase_d = PH_CHECK;
				end
				PH_CHECK: phase_d = PH_HUNT;
				default: begin
					if (rx_byte == BYTE_FRAME_START) phase_d = PH_GOT_FF;
					else if (rx_byte == BYTE_CTRL_START) phase_d = PH_GOT_FD;
					else phase_d = PH_HUNT;
				end
			endcase
		end else if (operation == OP_TICK) begin
			if (waiting_q) begin
				if (timer_inc >= limit) begin
					ack_timer_d = 16'd0;
					retry_d     = retry_bump;
				end else begin
					ack_timer_d = timer_inc;
				end
			end
		end else if (operation == OP_TX_DONE) begin
			waiting_d   = 1'b1;
			ack_timer_d = 16'd0;
			retry_d     = 8'd0;
		end
	end

	// Result caused by one item, if any.
	always_comb begin
		res_valid   = 1'b0;
		res_kind    = KIND_ACCEPT;
		res_code    = 8'd0;
		res_unknown = 1'b0;
		res_plen    = 8'd0;
		res_last    = 1'b1;
		start_emit  = 1'b0;
		ram_we      = 1'b0;
		if (operation == OP_RX_BYTE) begin
			unique case (phase_q)
				PH_GOT_FD: begin
					if (rx_byte == BYTE_CTRL_ACK) begin
						res_valid = 1'b1;
						res_kind  = KIND_ACK;
					end else if (rx_byte == BYTE_CTRL_NAK) begin
						res_valid = 1'b1;
						res_kind  = KIND_RESEND;
					end
				end
				PH_LEN: begin
					if (rx_byte == 8'd0) begin
						res_valid = 1'b1;
						res_kind  = KIND_DROPPED;
						res_code  = frame_code_q;
					end
				end
				PH_PAYLOAD: ram_we = (bytes_seen_q < MAX_LEN);
				PH_CHECK: begin
					res_valid = 1'b1;
					res_code  = frame_code_q;
					res_plen  = plen;
					if (plen > MAX_LEN) begin
						res_kind = KIND_DROPPED;
					end else if (sum_ok) begin
						res_kind    = KIND_ACCEPT;
						res_unknown = is_unknown(frame_code_q, host_mode_q);
						res_last    = (plen == 8'd0);
						start_emit  = (plen != 8'd0);
					end else begin
						res_kind = KIND_BAD_SUM;
					end
				end
				default: ;
			endcase
		end else if (operation == OP_TICK) begin
			if (waiting_q && timer_inc >= limit) begin
				res_valid = 1'b1;
				res_kind  = KIND_RESEND;
			end
		end else if (operation == OP_TX_DONE) begin
			res_valid = 1'b1;
			res_kind  = KIND_RETRY;
		end
	end

	// Control next state.
	always_comb begin
		ctrl_d = ctrl_q;
		unique case (ctrl_q)
			CTRL_ACCEPT: if (take && start_emit) ctrl_d = CTRL_READ;
			CTRL_READ:   ctrl_d = CTRL_WAIT;
			CTRL_WAIT: begin
				if (out_free) ctrl_d = (emit_idx_q == emit_end_q) ? CTRL_ACCEPT : CTRL_READ;
			end
			default:     ctrl_d = CTRL_ACCEPT;
		endcase
	end

	// Control outputs.
	always_comb begin
		in_ready  = 1'b0;
		ram_re    = 1'b0;
		byte_load = 1'b0;
		unique case (ctrl_q)
			CTRL_ACCEPT: in_ready  = out_free;
			CTRL_READ:   ram_re    = 1'b1;
			CTRL_WAIT:   byte_load = out_free;
			default: ;
		endcase
	end

	// Payload store; reads only follow the frame that wrote them, so no forwarding is needed.
	flr_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PAYLOAD),
		.AW   (AW)
	) u_payload_ram (
		.clk  (clk),
		.we   (take & ram_we),
		.waddr(bytes_seen_q[AW-1:0]),
		.wdata(rx_byte),
		.re   (ram_re),
		.raddr(emit_idx_q),
		.rdata(ram_rdata)
	);

	// Control and link state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q         <= CTRL_ACCEPT;
			phase_q        <= PH_HUNT;
			frame_code_q   <= 8'd0;
			frame_length_q <= 8'd0;
			bytes_seen_q   <= 8'd0;
			running_sum_q  <= 8'd0;
			waiting_q      <= 1'b0;
			ack_timer_q    <= 16'd0;
			retry_q        <= 8'd0;
			emit_idx_q     <= '0;
			emit_end_q     <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			ctrl_q <= ctrl_d;
			if (take) begin
				phase_q        <= phase_d;
				frame_code_q   <= frame_code_d;
				frame_length_q <= frame_length_d;
				bytes_seen_q   <= bytes_seen_d;
				running_sum_q  <= running_sum_d;
				waiting_q      <= waiting_d;
				ack_timer_q    <= ack_timer_d;
				retry_q        <= retry_d;
			end
			if (take && start_emit) begin
				emit_idx_q <= '0;
				emit_end_q <= AW'(plen - 8'd1);
			end else if (byte_load) begin
				emit_idx_q <= emit_idx_q + AW'(1);
			end
			if ((take && res_valid) || byte_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Result payload register; frame code and length stay put while bytes replay.
	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			kind_q        <= res_kind;
			msg_code_q    <= res_code;
			data_byte_q   <= 8'd0;
			unknown_q     <= res_unknown;
			payload_len_q <= res_plen;
			last_q        <= res_last;
			retries_q     <= retry_d;
		end else if (byte_load) begin
			kind_q      <= KIND_PAYLOAD;
			data_byte_q <= ram_rdata;
			unknown_q   <= 1'b0;
			last_q      <= (emit_idx_q == emit_end_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign msg_code     = msg_code_q;
	assign data_byte    = data_byte_q;
	assign unknown_code = unknown_q;
	assign payload_len  = payload_len_q;
	assign last         = last_q;
	assign retries      = retries_q;

endmodule

// ===== bench/framed_link_receiver_ack_retry_tb.sv =====
module framed_link_receiver_ack_retry_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import flr_pkg::*;

	localparam int PAYLOAD_DEPTH = 32;
	localparam int PAYLOAD_AW = $clog2(PAYLOAD_DEPTH);
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int ITEMS_PER_PHASE = 40;
	localparam int SETTLE_CYCLES = 80;

	// One result item as the block presents it.
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] code;
		logic [7:0] data;
		logic       unk;
		logic [7:0] plen;
		logic       last;
		logic [7:0] retries;
	} link_result_t;

	// One row of the directed stimulus; typed rows carry their own expected result.
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] value;
		logic       typed;
		logic [2:0] kind;
		logic [7:0] code;
		logic [7:0] plen;
		logic [7:0] retries;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = OP_RX_BYTE;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  msg_code;
	logic [7:0]  data_byte;
	logic        unknown_code;
	logic [7:0]  payload_len;
	logic        last;
	logic [7:0]  retries;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_ACK_TIMEOUT;
	logic [15:0] cfg_data = 16'd0;

	framed_link_receiver_ack_retry #(
		.MAX_PAYLOAD(PAYLOAD_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.msg_code(msg_code),
		.data_byte(data_byte),
		.unknown_code(unknown_code),
		.payload_len(payload_len),
		.last(last),
		.retries(retries),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Predicted copy of the receiver state and its registers.
	phase_t      rx_phase;
	logic [7:0]  cur_code;
	logic [7:0]  cur_len;
	logic [7:0]  payload_count;
	logic [7:0]  sum_acc;
	logic [7:0]  payload_mem [PAYLOAD_DEPTH];
	logic        awaiting_ack;
	logic [15:0] tick_count;
	logic [7:0]  resend_count;
	logic [15:0] cfg_timeout;
	logic        cfg_host;

	link_result_t step_results [$];
	link_result_t expected_results [$];

	int mismatch_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int kind_tally [8];
	int burst_left = 0;
	link_result_t monitor_got;
	link_result_t monitor_want;

	// Codes outside the handled set of the selected side need an unknown reply.
	function automatic logic code_unhandled(input logic [7:0] code);
		logic unk;
		case (code)
			8'h01, 8'h03, 8'h04, 8'h05, 8'h20, 8'h21: unk = 1'b0;
			8'h7f: unk = cfg_host;
			8'h81, 8'h82, 8'h83, 8'h86, 8'ha0, 8'hff: unk = ~cfg_host;
			default: unk = 1'b1;
		endcase
		return unk;
	endfunction

	function automatic phase_t start_phase_of(input logic [7:0] b);
		if (b == BYTE_FRAME_START)
			return PH_GOT_FF;
		if (b == BYTE_CTRL_START)
			return PH_GOT_FD;
		return PH_HUNT;
	endfunction

	function automatic link_result_t make_result(input logic [2:0] k, input logic [7:0] code,
			input logic [7:0] data, input logic unk, input logic [7:0] plen);
		link_result_t r;
		r.kind = k;
		r.code = code;
		r.data = data;
		r.unk = unk;
		r.plen = plen;
		r.last = 1'b0;
		r.retries = resend_count;
		return r;
	endfunction

	task automatic bump_resends();
		if (resend_count != 8'hff)
			resend_count = resend_count + 8'd1;
	endtask

	task automatic clear_link_model();
		rx_phase = PH_HUNT;
		cur_code = 8'h00;
		cur_len = 8'h00;
		payload_count = 8'h00;
		sum_acc = 8'h00;
		awaiting_ack = 1'b0;
		tick_count = 16'd0;
		resend_count = 8'd0;
		cfg_timeout = ACK_TIMEOUT_RESET;
		cfg_host = 1'b0;
	endtask

	// Work out the results that one accepted item causes, into step_results.
	task automatic predict_link_item(input logic [1:0] op, input logic [7:0] b);
		logic [7:0] plen;
		logic [7:0] want_sum;
		logic [15:0] limit;
		step_results.delete();
		case (op)
			OP_RX_BYTE: begin
				case (rx_phase)
					PH_GOT_FF: begin
						rx_phase = (b == BYTE_FRAME_MARK) ? PH_CODE : start_phase_of(b);
					end
					PH_GOT_FD: begin
						if (b == BYTE_CTRL_ACK) begin
							awaiting_ack = 1'b0;
							resend_count = 8'd0;
							step_results.push_back(make_result(KIND_ACK, 8'h00, 8'h00, 1'b0, 8'h00));
							rx_phase = PH_HUNT;
						end else if (b == BYTE_CTRL_NAK) begin
							tick_count = 16'd0;
							bump_resends();
							step_results.push_back(
								make_result(KIND_RESEND, 8'h00, 8'h00, 1'b0, 8'h00));
							rx_phase = PH_HUNT;
						end else begin
							rx_phase = start_phase_of(b);
						end
					end
					PH_CODE: begin
						cur_code = b;
						sum_acc = b;
						payload_count = 8'h00;
						rx_phase = PH_LEN;
					end
					PH_LEN: begin
						cur_len = b;
						sum_acc = sum_acc + b;
						if (b == 8'h00) begin
							step_results.push_back(
								make_result(KIND_DROPPED, cur_code, 8'h00, 1'b0, 8'h00));
							rx_phase = PH_HUNT;
						end else begin
							rx_phase = (b == 8'h01) ? PH_CHECK : PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						if (payload_count < PAYLOAD_DEPTH)
							payload_mem[payload_count[PAYLOAD_AW-1:0]] = b;
						payload_count = payload_count + 8'd1;
						sum_acc = sum_acc + b;
						if (int'(payload_count) + 1 >= int'(cur_len))
							rx_phase = PH_CHECK;
					end
					PH_CHECK: begin
						plen = cur_len - 8'd1;
						want_sum = 8'h00 - sum_acc;
						if (plen > PAYLOAD_DEPTH) begin
							step_results.push_back(
								make_result(KIND_DROPPED, cur_code, 8'h00, 1'b0, plen));
						end else if (want_sum == b) begin
							step_results.push_back(make_result(KIND_ACCEPT, cur_code, 8'h00,
								code_unhandled(cur_code), plen));
							for (int i = 0; i < plen; i++)
								step_results.push_back(make_result(KIND_PAYLOAD, cur_code,
									payload_mem[PAYLOAD_AW'(i)], 1'b0, plen));
						end else begin
							step_results.push_back(
								make_result(KIND_BAD_SUM, cur_code, 8'h00, 1'b0, plen));
						end
						rx_phase = PH_HUNT;
					end
					default: begin
						rx_phase = start_phase_of(b);
					end
				endcase
			end
			OP_TICK: begin
				if (awaiting_ack) begin
					if (tick_count != 16'hffff)
						tick_count = tick_count + 16'd1;
					limit = (cfg_timeout == 16'd0) ? 16'd1 : cfg_timeout;
					if (tick_count >= limit) begin
						tick_count = 16'd0;
						bump_resends();
						step_results.push_back(
							make_result(KIND_RESEND, 8'h00, 8'h00, 1'b0, 8'h00));
					end
				end
			end
			OP_TX_DONE: begin
				awaiting_ack = 1'b1;
				tick_count = 16'd0;
				resend_count = 8'd0;
				step_results.push_back(make_result(KIND_RETRY, 8'h00, 8'h00, 1'b0, 8'h00));
			end
			default: begin
			end
		endcase
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].last = 1'b1;
	endtask

	// Present one item, in bursts with random gaps, and predict it once it is taken.
	task automatic send_item(input logic [1:0] op, input logic [7:0] b);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
		in_valid <= 1'b1;
		operation <= op;
		rx_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		burst_left--;
		items_sent++;
		predict_link_item(op, b);
		foreach (step_results[i])
			expected_results.push_back(step_results[i]);
	endtask

	// Stop sending until every predicted result has been seen.
	task automatic hold_until_drained();
		int guard;
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		guard = 0;
		while (expected_results.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	// Drain, then let a payload replay still in flight finish before touching registers.
	task automatic settle_link();
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_link_config(input logic [15:0] timeout, input logic host);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ACK_TIMEOUT;
		cfg_data <= timeout;
		@(posedge clk);
		cfg_index <= CFG_HOST_MODE;
		cfg_data <= {15'd0, host};
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_timeout = timeout;
		cfg_host = host;
	endtask

	function automatic logic [7:0] pick_code();
		logic [7:0] code;
		case ($urandom_range(0, 17))
			0: code = 8'h01;
			1: code = 8'h03;
			2: code = 8'h04;
			3: code = 8'h05;
			4: code = 8'h20;
			5: code = 8'h21;
			6: code = 8'h7f;
			7: code = 8'h81;
			8: code = 8'h82;
			9: code = 8'h83;
			10: code = 8'h86;
			11: code = 8'ha0;
			12: code = 8'hff;
			default: code = 8'($urandom_range(0, 255));
		endcase
		return code;
	endfunction

	// A whole frame with random payload; ticks and transmit notices may fall inside it.
	task automatic send_frame(input logic [7:0] code, input int plen_bytes, input bit bad_sum);
		logic [7:0] lenb;
		logic [7:0] sum;
		logic [7:0] b;
		lenb = 8'(plen_bytes + 1);
		send_item(OP_RX_BYTE, BYTE_FRAME_START);
		send_item(OP_RX_BYTE, BYTE_FRAME_MARK);
		send_item(OP_RX_BYTE, code);
		send_item(OP_RX_BYTE, lenb);
		sum = code + lenb;
		for (int i = 0; i < plen_bytes; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(($urandom_range(0, 3) == 0) ? OP_TX_DONE : OP_TICK,
					8'($urandom_range(0, 255)));
			b = 8'($urandom_range(0, 255));
			sum = sum + b;
			send_item(OP_RX_BYTE, b);
		end
		b = 8'h00 - sum;
		if (bad_sum)
			b = b ^ 8'($urandom_range(1, 255));
		send_item(OP_RX_BYTE, b);
	endtask

	// Mostly well-formed traffic with random content, the rest noise and broken sequences.
	task automatic send_random_sequence();
		int pick;
		int plen;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			case ($urandom_range(0, 9))
				0, 1: plen = $urandom_range(7, PAYLOAD_DEPTH - 1);
				2: plen = PAYLOAD_DEPTH;
				default: plen = $urandom_range(0, 6);
			endcase
			send_frame(pick_code(), plen, 1'b0);
		end else if (pick < 55) begin
			send_frame(pick_code(), $urandom_range(0, 8), 1'b1);
		end else if (pick < 60) begin
			send_frame(pick_code(), $urandom_range(PAYLOAD_DEPTH + 1, PAYLOAD_DEPTH + 8),
				1'($urandom_range(0, 1)));
		end else if (pick < 64) begin
			send_item(OP_RX_BYTE, BYTE_FRAME_START);
			send_item(OP_RX_BYTE, BYTE_FRAME_MARK);
			send_item(OP_RX_BYTE, pick_code());
			send_item(OP_RX_BYTE, 8'h00);
		end else if (pick < 70) begin
			send_item(OP_RX_BYTE, BYTE_CTRL_START);
			send_item(OP_RX_BYTE, BYTE_CTRL_ACK);
		end else if (pick < 76) begin
			send_item(OP_RX_BYTE, BYTE_CTRL_START);
			send_item(OP_RX_BYTE, BYTE_CTRL_NAK);
		end else if (pick < 82) begin
			send_item(OP_TX_DONE, 8'($urandom_range(0, 255)));
		end else if (pick < 90) begin
			repeat ($urandom_range(1, 5)) send_item(OP_TICK, 8'($urandom_range(0, 255)));
		end else if (pick < 95) begin
			repeat ($urandom_range(1, 3)) send_item(OP_RX_BYTE, 8'($urandom_range(0, 255)));
		end else if (pick < 98) begin
			// A start byte of either kind followed by anything at all.
			send_item(OP_RX_BYTE, $urandom_range(0, 1) ? BYTE_FRAME_START : BYTE_CTRL_START);
			send_item(OP_RX_BYTE, 8'($urandom_range(0, 255)));
		end else begin
			send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_random_phase();
		int phase_start;
		phase_start = items_sent;
		while (items_sent - phase_start < ITEMS_PER_PHASE) begin
			send_random_sequence();
			if ($urandom_range(0, 24) == 0)
				hold_until_drained();
		end
	endtask

	// The result side stalls in styles picked at random along the run, one of them never stalling.
	logic [15:0] ready_cycle = 16'd0;
	logic [1:0]  ready_style = 2'd0;

	always @(posedge clk) begin
		ready_cycle <= ready_cycle + 16'd1;
		if (ready_cycle[5:0] == 6'd0)
			ready_style <= 2'($urandom_range(0, 3));
		case (ready_style)
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= 1'($urandom_range(0, 1));
			2'd2: out_ready <= (ready_cycle[1:0] == 2'd0);
			default: out_ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// Every result taken is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			monitor_got = '{kind, msg_code, data_byte, unknown_code, payload_len, last, retries};
			results_checked++;
			kind_tally[kind]++;
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: kind %0d code %02h data %02h unk %0d len %0d",
						kind, msg_code, data_byte, unknown_code, payload_len);
			end else begin
				monitor_want = expected_results.pop_front();
				if (monitor_got !== monitor_want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"result mismatch: expected kind %0d code %02h data %02h ",
							"unk %0d len %0d last %0d retries %0d, ",
							"got kind %0d code %02h data %02h unk %0d len %0d last %0d ",
							"retries %0d"},
							monitor_want.kind, monitor_want.code, monitor_want.data,
							monitor_want.unk, monitor_want.plen, monitor_want.last,
							monitor_want.retries, monitor_got.kind, monitor_got.code,
							monitor_got.data, monitor_got.unk, monitor_got.plen,
							monitor_got.last, monitor_got.retries);
				end
			end
		end
	end

	// Directed rows, run with an acknowledge timeout of one tick in device mode.
	directed_row_t directed_rows [26] = '{
		'{OP_TICK,    8'h00, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00},
		'{OP_UNUSED,  8'hff, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00},
		'{OP_TX_DONE, 8'h00, 1'b1, KIND_RETRY,  8'h00, 8'h00, 8'h00},
		'{OP_TICK,    8'hff, 1'b1, KIND_RESEND, 8'h00, 8'h00, 8'h01},
		'{OP_RX_BYTE, 8'hfd, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00},
		'{OP_RX_BYTE, 8'h03, 1'b1, KIND_RESEND, 8'h00, 8'h00, 8'h02},
		'{OP_RX_BYTE, 8'hfd, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00},
		'{OP_RX_BYTE, 8'h02, 1'b1, KIND_ACK,    8'h00, 8'h00, 8'h00},
		'{OP_RX_BYTE, 8'hfd, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00},
		'{OP_RX_BYTE, 8'h03, 1'b1, KIND_RESEND, 8'h00, 8'h00, 8'h01},
		'{OP_RX_BYTE, 8'hff, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00},
		'{OP_RX_BYTE, 8'hdd, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00},
		'{OP_RX_BYTE, 8'h05, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00},
		'{OP_RX_BYTE, 8'h00, 1'b1, KIND_DROPPED, 8'h05, 8'h00, 8'h01},
		'{OP_RX_BYTE, 8'hff, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00},
		'{OP_RX_BYTE, 8'hff, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00},
		'{OP_RX_BYTE, 8'hdd, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00},
		'{OP_RX_BYTE, 8'h7f, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00},
		'{OP_RX_BYTE, 8'h02, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00},
		'{OP_RX_BYTE, 8'haa, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00},
		'{OP_RX_BYTE, 8'h00, 1'b1, KIND_BAD_SUM, 8'h7f, 8'h01, 8'h01},
		'{OP_RX_BYTE, 8'hff, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00},
		'{OP_RX_BYTE, 8'hdd, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00},
		'{OP_RX_BYTE, 8'h00, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00},
		'{OP_RX_BYTE, 8'h01, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00},
		'{OP_RX_BYTE, 8'hff, 1'b0, KIND_ACCEPT, 8'h00, 8'h00, 8'h00}
	};

	// Main sequence: directed rows, three random phases, then a burst of timeouts.
	initial begin
		link_result_t typed_result;
		clear_link_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_link_config(16'd1, 1'b0);
		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].op, directed_rows[i].value);
			if (directed_rows[i].typed) begin
				repeat (step_results.size()) void'(expected_results.pop_back());
				typed_result = '{directed_rows[i].kind, directed_rows[i].code, 8'h00, 1'b0,
					directed_rows[i].plen, 1'b1, directed_rows[i].retries};
				expected_results.push_back(typed_result);
			end
		end
		settle_link();

		set_link_config(16'd3, 1'b1);
		send_frame(8'h21, PAYLOAD_DEPTH, 1'b0);
		run_random_phase();
		settle_link();

		// Longest timeout.
		set_link_config(16'hffff, 1'b0);
		run_random_phase();
		settle_link();

		set_link_config(16'd2, 1'b1);
		run_random_phase();
		settle_link();

		// Every tick times out, so each one raises the retry count.
		set_link_config(16'd1, 1'b0);
		send_item(OP_TX_DONE, 8'($urandom_range(0, 255)));
		repeat (12) send_item(OP_TICK, 8'($urandom_range(0, 255)));
		settle_link();

		$display("run covered %0d items and %0d results over five register settings",
			items_sent, results_checked);
		$display("  accepted %0d, payload %0d, bad sum %0d, ack %0d, resend %0d, dropped %0d",
			kind_tally[KIND_ACCEPT], kind_tally[KIND_PAYLOAD], kind_tally[KIND_BAD_SUM],
			kind_tally[KIND_ACK], kind_tally[KIND_RESEND], kind_tally[KIND_DROPPED]);
		if (expected_results.size() != 0)
			$display("%0d predicted results never arrived", expected_results.size());
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("framed_link_receiver_ack_retry_tb: clean");
		end else begin
			$display("%0d mismatches in total", mismatch_count);
			$display("framed_link_receiver_ack_retry_tb: errors");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#2000000;
		$display("timed out with %0d results outstanding", expected_results.size());
		$display("framed_link_receiver_ack_retry_tb: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/flr_pkg.sv
hw/rtl/flr_ram.sv
hw/rtl/framed_link_receiver_ack_retry.sv
bench/framed_link_receiver_ack_retry_tb.sv
